/* rtl/core/deq_pkg.sv */
package deq_pkg;

    // default number of entries in the ring of cells
    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned VALUE_W = 32;

    // request codes on s_kind
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_CLEAR      = 3'd4;

    // result status codes on m_status
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // value reported for front and back of an empty queue
    localparam logic signed [VALUE_W-1:0] EMPTY_READ = -32'sd1;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

endpackage

/* rtl/core/double_ended_queue_core.sv */
// channel  | handshake        | fields
// request  | s_valid s_ready  | s_kind s_value
// result   | m_valid m_ready  | m_status m_popped_value m_count_after m_front_value m_back_value
//
// one request per cycle while results are taken: the whole row of cells updates at the accepting edge
// and the result is valid from the next cycle on.
// front and back of the result are read straight from the cells, so a new
// request is taken only once no result waits or in the cycle it is taken.
// a stalled result holds the request channel stalled; nothing is dropped.
// reset empties the queue; stored words themselves are not cleared.
module double_ended_queue_core #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_kind,
    input  logic signed [deq_pkg::VALUE_W-1:0]    s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic signed [deq_pkg::VALUE_W-1:0]    m_popped_value,
    output logic [CNT_W-1:0]                      m_count_after,
    output logic signed [deq_pkg::VALUE_W-1:0]    m_front_value,
    output logic signed [deq_pkg::VALUE_W-1:0]    m_back_value
);

    logic                               accept;
    logic                               full;
    logic                               empty;
    deq_pkg::cell_ctrl_t                ctrl;
    deq_pkg::cell_op_t                  op;
    logic signed [deq_pkg::VALUE_W-1:0] front_data;
    logic                               front_valid;
    logic signed [deq_pkg::VALUE_W-1:0] back_data;

    logic                               m_valid_reg;
    logic [1:0]                         status_reg;
    logic [1:0]                         status_next;
    logic signed [deq_pkg::VALUE_W-1:0] popped_reg;
    logic signed [deq_pkg::VALUE_W-1:0] popped_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // request decode
    always_comb begin
        op          = deq_pkg::OP_HOLD;
        status_next = deq_pkg::STATUS_OK;
        popped_next = '0;
        count_next  = count_reg;
        unique case (s_kind) inside
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
                if (full) begin
                    status_next = deq_pkg::STATUS_FULL;
                end else begin
                    op = (s_kind == deq_pkg::KIND_PUSH_FRONT) ?
                         deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
                if (empty) begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end else if (s_kind == deq_pkg::KIND_POP_FRONT) begin
                    op          = deq_pkg::OP_POP_FRONT;
                    popped_next = front_data;
                    count_next  = count_reg - CNT_W'(1);
                end else begin
                    op          = deq_pkg::OP_POP_BACK;
                    popped_next = back_data;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::KIND_CLEAR: begin
                op         = deq_pkg::OP_CLEAR;
                count_next = '0;
            end
            default: begin
                op = deq_pkg::OP_HOLD;
            end
        endcase
    end

    // cells move only on an accepted request
    assign ctrl.op    = accept ? op : deq_pkg::OP_HOLD;
    assign ctrl.value = s_value;

    deq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .front_data  (front_data),
        .front_valid (front_valid),
        .back_data   (back_data)
    );

    // count and result word registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_popped_value = popped_reg;
    assign m_count_after  = count_reg;
    assign m_front_value  = empty ? deq_pkg::EMPTY_READ : front_data;
    assign m_back_value   = empty ? deq_pkg::EMPTY_READ : back_data;

    // count agrees with occupancy of the front cell
    a_count_matches_cells: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) == !front_valid
    ) else $error("count and cell occupancy disagree");

    // count never passes the depth
    a_count_bounded: assert property (
        @(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH)
    ) else $error("count beyond depth");

    // a refused request leaves the count alone
    a_refused_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && status_next != deq_pkg::STATUS_OK) |=> count_reg == $past(count_reg)
    ) else $error("refused request changed the count");

    // an empty refusal only when nothing is stored
    a_empty_only_when_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && status_next == deq_pkg::STATUS_EMPTY) |-> !front_valid
    ) else $error("pop refused with entries stored");

endmodule

/* rtl/core/deq_cell.sv */
module deq_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  deq_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [deq_pkg::VALUE_W-1:0]    left_data,
    input  logic                                  left_valid,
    input  logic signed [deq_pkg::VALUE_W-1:0]    right_data,
    input  logic                                  right_valid,
    output logic signed [deq_pkg::VALUE_W-1:0]    data,
    output logic                                  valid,
    output logic                                  last
);

    logic signed [deq_pkg::VALUE_W-1:0] data_reg;
    logic signed [deq_pkg::VALUE_W-1:0] data_next;
    logic                               valid_reg;
    logic                               valid_next;

    // next content of this cell from the broadcast operation and the neighbors
    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            deq_pkg::OP_PUSH_FRONT: begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            deq_pkg::OP_PUSH_BACK: begin
                // first free cell takes the word
                if (!valid_reg && left_valid) begin
                    data_next  = ctrl.value;
                    valid_next = 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            deq_pkg::OP_POP_BACK: begin
                if (valid_reg && !right_valid) begin
                    valid_next = 1'b0;
                end
            end
            deq_pkg::OP_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign last  = valid_reg && !right_valid;

endmodule

/* rtl/core/deq_chain.sv */
module deq_chain #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  deq_pkg::cell_ctrl_t                   ctrl,
    output logic signed [deq_pkg::VALUE_W-1:0]    front_data,
    output logic                                  front_valid,
    output logic signed [deq_pkg::VALUE_W-1:0]    back_data
);

    logic signed [deq_pkg::VALUE_W-1:0] data_w [DEPTH+1];
    logic [DEPTH:0]                     valid_w;
    logic [DEPTH-1:0]                   last_w;

    // nothing beyond the far end of the row
    assign data_w[DEPTH]  = '0;
    assign valid_w[DEPTH] = 1'b0;

    // row of cells, cell 0 holds the front
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [deq_pkg::VALUE_W-1:0] left_data;
        logic                               left_valid;

        if (i == 0) begin : g_head
            assign left_data  = ctrl.value;
            assign left_valid = 1'b1;
        end else begin : g_body
            assign left_data  = data_w[i-1];
            assign left_valid = valid_w[i-1];
        end

        deq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (data_w[i+1]),
            .right_valid (valid_w[i+1]),
            .data        (data_w[i]),
            .valid       (valid_w[i]),
            .last        (last_w[i])
        );
    end

    // at most one cell flags itself as the back, so an and-or select suffices
    always_comb begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (last_w[i]) begin
                back_data = back_data | data_w[i];
            end
        end
    end

    assign front_data  = data_w[0];
    assign front_valid = valid_w[0];

endmodule
